// ===== hdl/b64d_pkg.sv =====
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types for the base64 stream decoder: the decode job that the front
// part hands to the back part through the queue.
// ----------------------------------------------------------------------------
package b64d_pkg;

	localparam int unsigned JOB_BYTES = 3;

	typedef logic [1:0] b64_count_t;

	typedef struct packed {
		logic [8*JOB_BYTES-1:0] bytes;
		b64_count_t             count;
	} b64_job_t;

endpackage

// ===== hdl/b64d_front.sv =====
// ----------------------------------------------------------------------------
// b64d_front
// Accepts character items, maps them to sextets, collects groups of four and
// turns full groups and flushes into decode jobs of one to three bytes.
// ----------------------------------------------------------------------------
module b64d_front
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       end_of_stream,
	input  logic       queue_full,
	output logic       push,
	output b64_job_t   job
);

	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	logic [17:0] store_q;
	logic [1:0]  count_q;
	logic        accept;
	logic        char_ok;
	logic [5:0]  sextet;

	always_comb begin
		char_ok = 1'b1;
		sextet  = 6'd0;
		if (char_in >= 8'h41 && char_in <= 8'h5A) begin
			sextet = 6'(char_in - 8'h41);
		end else if (char_in >= 8'h61 && char_in <= 8'h7A) begin
			sextet = 6'(char_in - 8'h61 + 8'd26);
		end else if (char_in >= 8'h30 && char_in <= 8'h39) begin
			sextet = 6'(char_in - 8'h30 + 8'd52);
		end else if (char_in == CHAR_PLUS) begin
			sextet = 6'd62;
		end else if (char_in == CHAR_SLASH) begin
			sextet = 6'd63;
		end else begin
			char_ok = 1'b0;
		end
	end

	assign in_stall = queue_full;
	assign accept   = in_valid && !queue_full;

	always_comb begin
		push      = 1'b0;
		job.bytes = {store_q, sextet};
		job.count = 2'd3;
		if (end_of_stream) begin
			if (count_q == 2'd3) begin
				job.bytes = {store_q[17:2], 8'h00};
				job.count = 2'd2;
				push      = accept;
			end else if (count_q == 2'd2) begin
				job.bytes = {store_q[11:4], 16'h0000};
				job.count = 2'd1;
				push      = accept;
			end
		end else if (char_ok && count_q == 2'd3) begin
			push = accept;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			store_q <= '0;
			count_q <= '0;
		end else if (accept) begin
			if (end_of_stream || (char_ok && count_q == 2'd3)) begin
				store_q <= '0;
				count_q <= '0;
			end else if (char_ok) begin
				store_q <= {store_q[11:0], sextet};
				count_q <= count_q + 2'd1;
			end
		end
	end

endmodule

// ===== hdl/b64d_queue.sv =====
// ----------------------------------------------------------------------------
// b64d_queue
// Short first-in first-out queue of decode jobs between front and back.
// ----------------------------------------------------------------------------
module b64d_queue
	import b64d_pkg::*;
#(
	parameter int unsigned DEPTH = 4
)
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  b64_job_t push_job,
	input  logic     pop,
	output b64_job_t head_job,
	output logic     full,
	output logic     empty
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);

	b64_job_t        slots_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   fill_q;

	assign head_job = slots_q[rd_ptr_q];
	assign full     = (fill_q == CW'(DEPTH));
	assign empty    = (fill_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_SLOT) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + CW'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

endmodule

// ===== hdl/b64d_back.sv =====
// ----------------------------------------------------------------------------
// b64d_back
// Takes decode jobs from the queue and sends their bytes out one per cycle while
// out_stall is low, through an output register, marking the last byte of each job.
// ----------------------------------------------------------------------------
module b64d_back
	import b64d_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       job_valid,
	input  b64_job_t   job,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       last_in_run
);

	logic [8*JOB_BYTES-1:0] bytes_q;
	b64_count_t             rem_q;
	logic                   out_valid_q;
	logic [7:0]             data_q;
	logic                   last_q;
	logic                   load_out;
	logic                   emit;

	assign load_out = !out_valid_q || !out_stall;
	assign emit     = load_out && (rem_q != '0);
	assign pop      = job_valid && ((rem_q == '0) || (emit && rem_q == 2'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				rem_q <= job.count;
			end else if (emit) begin
				rem_q <= rem_q - 2'd1;
			end
			if (load_out) begin
				out_valid_q <= emit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bytes_q <= job.bytes;
		end else if (emit) begin
			bytes_q <= {bytes_q[8*JOB_BYTES-9:0], 8'h00};
		end
		if (emit) begin
			data_q <= bytes_q[8*JOB_BYTES-1 -: 8];
			last_q <= (rem_q == 2'd1);
		end
	end

	assign out_valid   = out_valid_q;
	assign data_byte   = data_q;
	assign last_in_run = last_q;

endmodule

// ===== hdl/base64_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// base64_stream_decoder_core
// Streaming base64 decoder: one character item in, decoded bytes out.
// ----------------------------------------------------------------------------
// The input channel (in_valid, in_stall, char_in, end_of_stream) takes one item
// per cycle while in_stall is low. Characters outside the base64 alphabet are
// dropped. Every fourth valid character, and every end-of-stream item that
// holds two or three sextets, creates a job of three, one or two bytes in a
// queue of QUEUE_DEPTH jobs. The output channel (out_valid, out_stall,
// data_byte, last_in_run) sends one byte per cycle while out_stall is low;
// last_in_run marks the final byte of each item's run. With the back end idle,
// a job passes from the queue into the back end's byte register, and its first
// byte then into the output register; bytes of earlier jobs still in the queue
// are sent first. Sustained input rate is one item per cycle while out_stall is
// low, since four characters yield at most three bytes and the back end emits
// one byte per cycle. When the receiver stalls, the output register holds its
// byte, the queue fills, and in_stall rises once it holds QUEUE_DEPTH jobs.
// Reset clears the group, the queue and the output valid.
// ----------------------------------------------------------------------------
module base64_stream_decoder_core
	import b64d_pkg::*;
#(
	parameter int unsigned QUEUE_DEPTH = 4
)
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_in,
	input  logic       end_of_stream,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       last_in_run
);

	b64_job_t push_job;
	b64_job_t head_job;
	logic     push;
	logic     pop;
	logic     full;
	logic     empty;

	b64d_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_in      (char_in),
		.end_of_stream(end_of_stream),
		.queue_full   (full),
		.push         (push),
		.job          (push_job)
	);

	b64d_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head_job(head_job),
		.full    (full),
		.empty   (empty)
	);

	b64d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.job_valid  (!empty),
		.job        (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.last_in_run(last_in_run)
	);

endmodule
